/* design/assert_macros.svh */
// Assertion macros shared by the modular inverse search RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MIS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset.
`define MIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* design/mis_pkg.sv */
// Shared types for the modular inverse search block.
// Used by mis_div and modular_inverse_search; depends on nothing.
package mis_pkg;

    // Control from the sequencer to the divide unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status from the divide unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* design/mis_div.sv */
// Shift-subtract divide unit with a running quotient-times-multiplier product.
// Depends on mis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mis_div #(
    parameter int WIDTH = 34
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mis_pkg::div_ctrl_t        ctrl,
    input  logic [WIDTH-1:0]          dividend,
    input  logic [WIDTH-1:0]          divisor,
    input  logic signed [WIDTH+1:0]   mult,
    output mis_pkg::div_stat_t        stat,
    output logic [WIDTH-1:0]          rem,
    output logic signed [WIDTH+1:0]   prod
);

    localparam int TW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [WIDTH-1:0]       num_reg;
    logic [WIDTH-1:0]       dvs_reg;
    logic [WIDTH-1:0]       rem_reg;
    logic [WIDTH-1:0]       rem_next;
    logic signed [TW-1:0]   mult_reg;
    logic signed [TW-1:0]   prod_reg;
    logic signed [TW-1:0]   prod_next;
    logic [WIDTH:0]         trial;
    logic [WIDTH:0]         trial_sub;
    logic                   ge;

    // One quotient bit per cycle: shift in the next dividend bit, try the subtract
    always_comb begin
        trial     = {rem_reg, num_reg[WIDTH-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        rem_next  = ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
        prod_next = (prod_reg <<< 1) + (ge ? mult_reg : '0);
    end

    // Control: load on start, count down the quotient bits, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands and partial results
    always_ff @(posedge aclk) begin
        if (ctrl.start && !busy_reg) begin
            num_reg  <= dividend;
            dvs_reg  <= divisor;
            mult_reg <= mult;
            rem_reg  <= '0;
            prod_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= num_reg << 1;
            rem_reg  <= rem_next;
            prod_reg <= prod_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;
    assign prod      = prod_reg;

    `MIS_ASSERT_NOW(a_start_idle, aclk, aresetn, ctrl.start, !busy_reg)
    `MIS_ASSERT_NEXT(a_last_bit_done, aclk, aresetn, busy_reg && cnt_reg == CW'(1), done_reg)
    `MIS_ASSERT_NOW(a_rem_below_divisor, aclk, aresetn, done_reg, rem_reg < dvs_reg)

endmodule

/* design/modular_inverse_search.sv */
// Channel | Dir | Fields (low bit first)               | Accepted when
// s_      | in  | tdata: exponent, modulus_phi         | s_tvalid && s_tready
// m_      | out | tdata: inverse                       | m_tvalid && m_tready
//
// Extended Euclid over (modulus_phi, exponent); every quotient comes from one
// shared shift-subtract divide unit.
// The number of divide steps per item is at most about 1.44 * WIDTH + 2.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register and stalls only the next result, not the next request.
// Reset is synchronous on aresetn; no clearing pass is needed.
// Depends on mis_pkg, mis_div and assert_macros.svh.
`include "assert_macros.svh"

module modular_inverse_search #(
    parameter int WIDTH = 34
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*WIDTH+7)/8)*8-1:0]         s_tdata,  // exponent, modulus_phi
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((WIDTH+7)/8)*8-1:0]           m_tdata   // inverse
);

    localparam int TW  = WIDTH + 2;
    localparam int MDW = ((WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic                   m_tvalid_reg;
    logic [WIDTH-1:0]       m_data_reg;
    logic [WIDTH-1:0]       res_reg;
    logic [WIDTH-1:0]       phi_reg;
    logic [WIDTH-1:0]       r0_reg;
    logic [WIDTH-1:0]       r1_reg;
    logic signed [TW-1:0]   t0_reg;
    logic signed [TW-1:0]   t1_reg;

    logic [WIDTH-1:0]       in_exp;
    logic [WIDTH-1:0]       in_phi;
    logic signed [TW-1:0]   t_pos;
    logic [WIDTH-1:0]       res_next;
    logic                   out_free;

    mis_pkg::div_ctrl_t     div_ctrl;
    mis_pkg::div_stat_t     div_stat;
    logic [WIDTH-1:0]       div_rem;
    logic signed [TW-1:0]   div_prod;

    assign in_exp = s_tdata[WIDTH-1:0];
    assign in_phi = s_tdata[2*WIDTH-1:WIDTH];

    // Fold a negative coefficient into [0, phi) and pick the answer
    always_comb begin
        t_pos = t0_reg[TW-1] ? (t0_reg + TW'(phi_reg)) : t0_reg;
        if (r0_reg != WIDTH'(1) || t_pos < TW'(2)) begin
            res_next = WIDTH'(1);
        end else begin
            res_next = t_pos[WIDTH-1:0];
        end
    end

    assign out_free       = !m_tvalid_reg || m_tready;
    assign div_ctrl.start = (state_reg == ST_CHECK) && (r1_reg != '0);

    mis_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (r0_reg),
        .divisor  (r1_reg),
        .mult     (t1_reg),
        .stat     (div_stat),
        .rem      (div_rem),
        .prod     (div_prod)
    );

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // drop a taken result unless a new one replaces it this cycle
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (in_phi < WIDTH'(2)) begin
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r1_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FIN: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Euclid registers and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    phi_reg <= in_phi;
                    r0_reg  <= in_phi;
                    r1_reg  <= in_exp;
                    t0_reg  <= '0;
                    t1_reg  <= TW'(1);
                    res_reg <= WIDTH'(1);
                end
            end
            ST_CHECK: begin
                if (r1_reg == '0) begin
                    res_reg <= res_next;
                end
            end
            ST_DIV: begin
                // advance one Euclid step: (r0, r1) <- (r1, r0 mod r1)
                if (div_stat.done) begin
                    r0_reg <= r1_reg;
                    r1_reg <= div_rem;
                    t0_reg <= t1_reg;
                    t1_reg <= t0_reg - div_prod;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_reg <= res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MDW'(m_data_reg);

    `MIS_ASSERT_NOW(a_done_in_div, aclk, aresetn, div_stat.done, state_reg == ST_DIV)
    `MIS_ASSERT_NOW(a_ready_unit_idle, aclk, aresetn, s_tready, !div_stat.busy)
    `MIS_ASSERT_NOW(a_result_nonzero, aclk, aresetn, m_tvalid_reg, m_data_reg != '0)

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for modular_inverse_search: directed table, then random requests.
// Predicts each inverse the directed table does not type in by extended Euclid and checks every result in order.
// Depends only on the modular_inverse_search RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIDTH = 34;
    localparam int S_BITS = ((2 * WIDTH + 7) / 8) * 8;
    localparam int M_BITS = ((WIDTH + 7) / 8) * 8;
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM = 77;
    localparam int DRAIN_CYCLES = 2000;
    localparam logic [WIDTH-1:0] FIELD_MAX = '1;
    localparam logic [WIDTH-1:0] NO_INVERSE = 1;
    localparam logic [WIDTH-1:0] FIB_49 = 34'd7778742049;
    localparam logic [WIDTH-1:0] FIB_50 = 34'd12586269025;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    typedef struct {
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        bit               typed;
        logic [WIDTH-1:0] inverse;
    } inverse_vector_t;

    typedef struct {
        logic [WIDTH-1:0] inverse;
        int               request_id;
    } pending_inverse_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [M_BITS-1:0] m_tdata;

    pending_inverse_t pending_inverses[$];
    int mismatch_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int no_inverse_seen = 0;

    // Directed requests; inverse is typed in where it is obvious, else predicted
    inverse_vector_t directed_vectors [NUM_DIRECTED] = '{
        '{34'd3, 34'd0, 1'b1, NO_INVERSE},                  // modulus zero
        '{34'd5, 34'd1, 1'b1, NO_INVERSE},                  // modulus one
        '{34'd0, 34'd100, 1'b1, NO_INVERSE},                // exponent zero
        '{34'd1, 34'd100, 1'b1, NO_INVERSE},                // exponent is one
        '{34'd101, 34'd100, 1'b1, NO_INVERSE},              // congruent to one
        '{34'd200, 34'd100, 1'b1, NO_INVERSE},              // multiple of modulus
        '{34'd6, 34'd9, 1'b1, NO_INVERSE},                  // common factor
        '{34'd3, 34'd7, 1'b1, 34'd5},
        '{34'd2, 34'd3, 1'b1, 34'd2},
        '{34'd1, 34'd2, 1'b1, NO_INVERSE},                  // smallest modulus
        '{34'd17, 34'd3120, 1'b1, 34'd2753},
        '{34'd65537, 34'd3120, 1'b0, '0},
        '{FIELD_MAX - 1, FIELD_MAX, 1'b1, FIELD_MAX - 1},   // minus one is self-inverse
        '{FIELD_MAX, FIELD_MAX, 1'b1, NO_INVERSE},
        '{FIELD_MAX, 34'd2, 1'b1, NO_INVERSE},
        '{FIELD_MAX, FIELD_MAX - 1, 1'b1, NO_INVERSE},
        '{34'd3, FIELD_MAX, 1'b1, NO_INVERSE},              // 3 divides 2^34-1
        '{34'h2_0000_0000, FIELD_MAX, 1'b1, 34'd2},
        '{FIB_49, FIB_50, 1'b0, '0},                        // longest Euclid chain
        '{34'd65537, FIELD_MAX, 1'b0, '0},
        '{34'h2_AAAA_AAAB, 34'h3_FFFF_FFF0, 1'b0, '0},
        '{FIELD_MAX, 34'h2_0000_0000, 1'b0, '0},
        '{34'h1_5555_5555, 34'h3_FFFF_FFFD, 1'b0, '0}
    };

    modular_inverse_search #(.WIDTH(WIDTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Extended Euclid; 1 stands for "no candidate in [2, modulus-1]"
    function automatic logic [WIDTH-1:0] predict_inverse(logic [WIDTH-1:0] exponent,
                                                         logic [WIDTH-1:0] modulus);
        longint r_prev, r_cur, r_next, t_prev, t_cur, t_next, quot, mod_l;
        if (modulus < 2) begin
            return NO_INVERSE;
        end
        mod_l = longint'(modulus);
        r_prev = mod_l;
        r_cur = longint'(exponent) % mod_l;
        t_prev = 0;
        t_cur = 1;
        while (r_cur != 0) begin
            quot = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            t_next = t_prev - quot * t_cur;
            r_prev = r_cur;
            r_cur = r_next;
            t_prev = t_cur;
            t_cur = t_next;
        end
        if (r_prev != 1) begin
            return NO_INVERSE;
        end
        if (t_prev < 0) begin
            t_prev = t_prev + mod_l;
        end
        if (t_prev < 2) begin
            return NO_INVERSE;
        end
        return t_prev[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] random_field();
        logic [WIDTH-1:0] value;
        value[31:0] = $urandom();
        value[WIDTH-1:32] = (WIDTH - 32)'($urandom_range(3, 0));
        return value;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Reset, held low at the start and then released
    initial begin
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: stall on phases of random length and style
    initial begin
        ready_mode_t mode;
        int phase_left;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = ready_mode_t'($urandom_range(2, 0));
            phase_left = $urandom_range(200, 10);
            repeat (phase_left) begin
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(1, 0));
                    default:      m_tready <= ($urandom_range(7, 0) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Check each result against the oldest pending inverse
    always @(posedge aclk) begin
        pending_inverse_t head;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[WIDTH-1:0] == NO_INVERSE) begin
                no_inverse_seen++;
            end
            if (pending_inverses.size() == 0) begin
                $error("inverse: result 0x%0h arrived with no request pending",
                       m_tdata[WIDTH-1:0]);
                mismatch_count++;
            end else begin
                head = pending_inverses.pop_front();
                if (m_tdata[WIDTH-1:0] !== head.inverse) begin
                    $error("inverse (request %0d): expected 0x%0h, actual 0x%0h",
                           head.request_id, head.inverse, m_tdata[WIDTH-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Drive one request, hold it until accepted, then record the expected inverse
    int burst_left = 0;

    task automatic send_request(input logic [WIDTH-1:0] exponent,
                                input logic [WIDTH-1:0] modulus,
                                input bit typed, input logic [WIDTH-1:0] typed_inverse);
        pending_inverse_t entry;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 1);
        end
        s_tdata <= {{(S_BITS - 2 * WIDTH){1'b0}}, modulus, exponent};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        entry.inverse = typed ? typed_inverse : predict_inverse(exponent, modulus);
        entry.request_id = requests_sent;
        pending_inverses = {pending_inverses, entry};
        requests_sent++;
        burst_left--;
        // Close the burst with a random gap
        if (burst_left == 0) begin
            gap = $urandom_range(40, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random request shaped toward one of several regions of behavior
    task automatic send_random_request();
        logic [WIDTH-1:0] exponent, modulus;
        longint factor, scale;
        exponent = random_field();
        modulus = random_field();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: begin
                if (modulus < 2) modulus = WIDTH'(2);
            end
            4, 5: begin
                modulus = WIDTH'($urandom_range(1000, 2));
                exponent = WIDTH'($urandom_range(5000, 1));
            end
            6: begin
                if (modulus < 3) modulus = WIDTH'(3);
                case ($urandom_range(2, 0))
                    0: exponent = modulus - 1;
                    1: exponent = (modulus == FIELD_MAX) ? 1 : modulus + 1;
                    default: exponent = WIDTH'(modulus * $urandom_range(3, 1));
                endcase
            end
            7: begin
                // Force a shared factor
                factor = $urandom_range(50, 2);
                scale = $urandom_range(32'h0FFF_FFFF, 1);
                modulus = WIDTH'(factor * scale);
                exponent = WIDTH'(factor * $urandom_range(32'h0FFF_FFFF, 1));
            end
            8: begin
                modulus[WIDTH-1] = 1'b1;
                exponent = exponent % modulus;
                if (exponent == 0) exponent = WIDTH'(1);
            end
            default: begin
                // Degenerate inputs now and then
                if ($urandom_range(1, 0) == 1) begin
                    modulus = WIDTH'($urandom_range(1, 0));
                end else begin
                    exponent = '0;
                end
            end
        endcase
        send_request(exponent, modulus, 1'b0, '0);
    endtask

    // Stimulus and end of run
    initial begin
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        foreach (directed_vectors[i]) begin
            send_request(directed_vectors[i].exponent, directed_vectors[i].modulus,
                         directed_vectors[i].typed, directed_vectors[i].inverse);
        end
        repeat (NUM_RANDOM) send_random_request();
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_inverses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests (%0d from the directed table) and checked %0d results,",
                 requests_sent, NUM_DIRECTED, results_seen);
        $display("%0d of them without an inverse.", no_inverse_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timed out with %0d results still pending", pending_inverses.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/mis_pkg.sv
design/mis_div.sv
design/modular_inverse_search.sv
tb/sv/tb_top.sv
